/* rtl/bca_pkg.sv */
// Shared types, constants and helpers for the bitmap cluster allocator.
package bca_pkg;

    localparam int MAP_BYTES_DEF = 2048;

    localparam int COUNT_W     = 15;
    localparam int POS_W       = 14;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;
    localparam int WORD_BITS   = 64;
    localparam int WORD_SHIFT  = 6;
    localparam int IDX_W       = COUNT_W - WORD_SHIFT;

    localparam logic [COUNT_W-1:0] RESET_COUNT = 15'd16384;

    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  found_cluster;
    } result_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE
    } state_t;

    // index of the lowest set bit; zero when none is set
    function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_SHIFT-1:0] r;
        r = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (v[j])
            begin
                r = WORD_SHIFT'(j);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/bitmap_cluster_allocator.sv */
// Free-space bitmap cluster allocator: find first free cluster, set and clear cluster bits.
//
// The map is held as 64-bit memory words, one bit per cluster. After reset the block
// runs a clearing pass over all ceil(MAP_BYTES/8) words (256 at the default size) with
// busy high. A find reads one word per cycle through the single memory read port; a
// find with a usable count of zero answers at once. A set or clear in range is a
// read-modify-write of the word holding the cluster bit; an out-of-range or unknown
// request answers at once. Each result appears for one cycle with done high, the cycle
// after the request ends, and cannot be held off, so it must be captured then. The user
// must write cluster_count only while the block is idle; the block does not enforce it.
module bitmap_cluster_allocator #(
    parameter int MAP_BYTES = bca_pkg::MAP_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bca_pkg::request_t             request,
    output logic                          busy,
    output logic                          done,
    output bca_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [bca_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int WORDS    = (MAP_BYTES + 7) / 8;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MAP_BITS = MAP_BYTES * 8;
    localparam int MAX_CNT  = (1 << bca_pkg::COUNT_W) - 1;
    localparam int CAP      = (MAP_BITS > MAX_CNT) ? MAX_CNT : MAP_BITS;
    localparam logic [bca_pkg::COUNT_W-1:0] CAP_W      = bca_pkg::COUNT_W'(CAP);
    localparam logic [AW-1:0]               LAST_ENTRY = AW'(WORDS - 1);

    bca_pkg::state_t                     state_reg, state_next;
    logic [bca_pkg::COUNT_W-1:0]         cluster_count_reg;
    logic [bca_pkg::IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic [AW-1:0]                       clr_addr_reg, clr_addr_next;
    logic [bca_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [bca_pkg::ACT_W-1:0]           act_reg, act_next;
    logic                                done_reg, done_next;
    bca_pkg::result_t                    result_reg, result_next;

    logic [bca_pkg::COUNT_W-1:0]         limit;
    logic [bca_pkg::COUNT_W-1:0]         limit_m1;
    logic [bca_pkg::IDX_W-1:0]           last_word;
    logic [bca_pkg::WORD_BITS-1:0]       tail_mask;
    logic [bca_pkg::WORD_BITS-1:0]       free_bits;
    logic [bca_pkg::WORD_BITS-1:0]       bit_sel;
    logic [bca_pkg::COUNT_W-1:0]         found_wide;
    logic [bca_pkg::IDX_W-1:0]           rd_idx;
    logic [bca_pkg::IDX_W-1:0]           pos_idx;
    logic [bca_pkg::IDX_W+AW-1:0]        rd_wide;
    logic [bca_pkg::IDX_W+AW-1:0]        pos_wide;
    logic [AW-1:0]                       rd_addr;
    logic [AW-1:0]                       wr_addr;
    logic                                wr_en;
    logic [bca_pkg::WORD_BITS-1:0]       wr_data;
    logic [bca_pkg::WORD_BITS-1:0]       rd_data;

    bca_map_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // usable count is the smaller of the register and the map size
    assign limit     = (cluster_count_reg < CAP_W) ? cluster_count_reg : CAP_W;
    assign limit_m1  = limit - bca_pkg::COUNT_W'(1);
    assign last_word = limit_m1[bca_pkg::COUNT_W-1:bca_pkg::WORD_SHIFT];

    assign tail_mask = ((chk_idx_reg == last_word) && (limit[bca_pkg::WORD_SHIFT-1:0] != '0))
                       ? ((bca_pkg::WORD_BITS'(1) << limit[bca_pkg::WORD_SHIFT-1:0])
                          - bca_pkg::WORD_BITS'(1))
                       : '1;
    assign free_bits  = ~rd_data & tail_mask;
    assign found_wide = {chk_idx_reg, bca_pkg::lowest_set(free_bits)};
    assign bit_sel    = bca_pkg::WORD_BITS'(1) << pos_reg[bca_pkg::WORD_SHIFT-1:0];

    assign pos_idx  = bca_pkg::IDX_W'(pos_reg[bca_pkg::POS_W-1:bca_pkg::WORD_SHIFT]);
    assign pos_wide = {{AW{1'b0}}, pos_idx};
    assign rd_wide  = {{AW{1'b0}}, rd_idx};
    assign rd_addr  = rd_wide[AW-1:0];

    assign busy   = (state_reg != bca_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        chk_idx_next  = chk_idx_reg;
        clr_addr_next = clr_addr_reg;
        pos_next      = pos_reg;
        act_next      = act_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        rd_idx        = '0;
        wr_en         = 1'b0;
        wr_addr       = pos_wide[AW-1:0];
        wr_data       = '0;

        case (state_reg)
            bca_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == LAST_ENTRY)
                begin
                    state_next = bca_pkg::S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            bca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next = request.action;
                    pos_next = request.position;
                    rd_idx   = bca_pkg::IDX_W'(
                        request.position[bca_pkg::POS_W-1:bca_pkg::WORD_SHIFT]);
                    case (request.action)
                        bca_pkg::ACT_FIND:
                        begin
                            rd_idx = '0;
                            if (limit == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: bca_pkg::ST_FULL, found_cluster: '0};
                            end
                            else
                            begin
                                chk_idx_next = '0;
                                state_next   = bca_pkg::S_SCAN;
                            end
                        end
                        bca_pkg::ACT_SET, bca_pkg::ACT_CLEAR:
                        begin
                            if ({1'b0, request.position} >= limit)
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: bca_pkg::ST_RANGE, found_cluster: '0};
                            end
                            else
                            begin
                                state_next = bca_pkg::S_WRITE;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: bca_pkg::ST_DONE, found_cluster: '0};
                        end
                    endcase
                end
            end

            bca_pkg::S_SCAN:
            begin
                // rd_data holds word chk_idx; the next word is fetched meanwhile
                rd_idx = chk_idx_reg + bca_pkg::IDX_W'(1);
                if (free_bits != '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: bca_pkg::ST_DONE,
                                    found_cluster: found_wide[bca_pkg::POS_W-1:0]};
                    state_next  = bca_pkg::S_IDLE;
                end
                else if (chk_idx_reg == last_word)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: bca_pkg::ST_FULL, found_cluster: '0};
                    state_next  = bca_pkg::S_IDLE;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + bca_pkg::IDX_W'(1);
                end
            end

            bca_pkg::S_WRITE:
            begin
                wr_en       = 1'b1;
                wr_data     = (act_reg == bca_pkg::ACT_SET) ? (rd_data | bit_sel)
                                                            : (rd_data & ~bit_sel);
                done_next   = 1'b1;
                result_next = '{status: bca_pkg::ST_DONE, found_cluster: '0};
                state_next  = bca_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bca_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bca_pkg::S_CLEAR;
            cluster_count_reg <= bca_pkg::RESET_COUNT;
            chk_idx_reg       <= '0;
            clr_addr_reg      <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_idx_reg  <= chk_idx_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                cluster_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        act_reg    <= act_next;
        result_reg <= result_next;
    end

endmodule

/* rtl/bca_map_ram.sv */
// Single-port-write, single-port-read map memory with registered read data.
module bca_map_ram #(
    parameter int WORDS = 256,
    parameter int AW    = 8
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [bca_pkg::WORD_BITS-1:0]  wr_data,
    input  logic [AW-1:0]                  rd_addr,
    output logic [bca_pkg::WORD_BITS-1:0]  rd_data
);

    logic [bca_pkg::WORD_BITS-1:0] mem [WORDS];
    logic [bca_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bca_checker.sv */
// Port-level checks for the bitmap cluster allocator, bound to the top level.
module bca_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input bca_pkg::request_t request,
    input logic              busy,
    input logic              done,
    input bca_pkg::result_t  result
);

    // a result word only leaves once the request has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == bca_pkg::ST_DONE || result.status == bca_pkg::ST_RANGE
                  || result.status == bca_pkg::ST_FULL))
        else $error("unknown status code");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != bca_pkg::ST_DONE)) |-> (result.found_cluster == '0))
        else $error("cluster number on a failed request");

    a_unused_act: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.action == bca_pkg::ACT_UNUSED))
        |=> (done && (result.status == bca_pkg::ST_DONE) && (result.found_cluster == '0)))
        else $error("unknown action not answered at once");

    a_find_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.action == bca_pkg::ACT_FIND)) |=> (busy || done))
        else $error("find neither scanning nor answered");

endmodule

bind bitmap_cluster_allocator bca_checker u_bca_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

/* tb/sv/cluster_alloc_tb_pkg.sv */
// Scoreboard for the bitmap cluster allocator: cluster map model and result queue.
package cluster_alloc_tb_pkg;

    import bca_pkg::*;

    localparam int MAP_BITS = MAP_BYTES_DEF * 8;

    class allocation_scoreboard;

        logic [7:0]  used_map [MAP_BYTES_DEF];
        int unsigned usable_clusters;
        result_t     pending_outcomes [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned n_find;
        int unsigned n_full;
        int unsigned n_set;
        int unsigned n_clear;
        int unsigned n_other;
        int unsigned n_range;

        function new();
            foreach (used_map[i])
                used_map[i] = '0;
            usable_clusters = 32'(RESET_COUNT);
        endfunction

        // counts past the end of the map are clipped to the map size
        function void set_count(input logic [COUNT_W-1:0] v);
            usable_clusters = (32'(v) > MAP_BITS) ? MAP_BITS : 32'(v);
        endfunction

        function result_t predict_outcome(input request_t r);
            result_t     o;
            int unsigned p;
            bit          hit;
            o.status        = ST_DONE;
            o.found_cluster = '0;
            hit             = 1'b0;
            p               = 0;
            case (r.action)
                ACT_FIND:
                begin
                    n_find++;
                    while (!hit && p < usable_clusters)
                    begin
                        // whole byte used: jump to the next one
                        if (used_map[p >> 3] == 8'hFF)
                            p = (p | 7) + 1;
                        else if (!used_map[p >> 3][7 - (p & 7)])
                            hit = 1'b1;
                        else
                            p++;
                    end
                    if (hit)
                        o.found_cluster = POS_W'(p);
                    else
                    begin
                        o.status = ST_FULL;
                        n_full++;
                    end
                end
                ACT_SET, ACT_CLEAR:
                begin
                    if (r.action == ACT_SET)
                        n_set++;
                    else
                        n_clear++;
                    if (32'(r.position) >= usable_clusters)
                    begin
                        o.status = ST_RANGE;
                        n_range++;
                    end
                    else
                    begin
                        // MSB first within each byte
                        used_map[r.position >> 3][7 - r.position[2:0]] = (r.action == ACT_SET);
                    end
                end
                default:
                    n_other++;
            endcase
            return o;
        endfunction

        function void note_request(input request_t r);
            pending_outcomes.push_back(predict_outcome(r));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: no word expected, got status %0d cluster %0d",
                             mismatches, got.status, got.found_cluster);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.status !== want.status || got.found_cluster !== want.found_cluster)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: expected %0d/%0d, got %0d/%0d (status/cluster)",
                             mismatches, want.status, want.found_cluster,
                             got.status, got.found_cluster);
            end
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction

    endclass

endpackage

/* tb/sv/tb_bitmap_cluster_allocator.sv */
// Testbench top for the bitmap cluster allocator: directed and random requests.
module tb_bitmap_cluster_allocator;

    import bca_pkg::*;
    import cluster_alloc_tb_pkg::*;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    request_t           request  = '0;
    logic               cfg_we   = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               busy;
    logic               done;
    result_t            result;

    allocation_scoreboard board;
    int unsigned          n_sent;
    int unsigned          n_writes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bitmap_cluster_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // results cannot be held off: take every word on its one cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos);
        request_t r;
        r.action   = act;
        r.position = pos;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        board.note_request(r);
        n_sent++;
    endtask

    task automatic idle_for(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // drains everything outstanding before touching the register
    task automatic write_count(input logic [COUNT_W-1:0] v);
        idle_for(1);
        while (board.pending() != 0 || busy)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_count(v);
        n_writes++;
    endtask

    task automatic run_directed();
        send_request(ACT_FIND, '0);
        send_request(ACT_SET, '0);
        send_request(ACT_FIND, 14'h3FFF);
        send_request(ACT_SET, 14'h3FFF);
        send_request(ACT_CLEAR, 14'h3FFF);
        send_request(ACT_CLEAR, 14'h3FFF);
        send_request(ACT_SET, '0);
        send_request(ACT_UNUSED, 14'h2AAA);
        send_request(ACT_UNUSED, 14'h1555);
        // zero clusters: nothing to find, everything out of range
        write_count('0);
        send_request(ACT_FIND, '0);
        send_request(ACT_SET, '0);
        send_request(ACT_CLEAR, '0);
        // count beyond the map is clipped
        write_count(15'h7FFF);
        send_request(ACT_SET, 14'h3FFF);
        send_request(ACT_FIND, '0);
        write_count(15'd1);
        send_request(ACT_SET, 14'd1);
        send_request(ACT_FIND, '0);
        send_request(ACT_CLEAR, '0);
        send_request(ACT_FIND, '0);
        write_count(RESET_COUNT);
        send_request(ACT_CLEAR, 14'h3FFF);
        send_request(ACT_FIND, '0);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned        target;
        int unsigned        usable;
        int unsigned        span;
        int unsigned        fill_ptr;
        int unsigned        len;
        int unsigned        roll;
        int unsigned        gap;
        bit                 quiet;
        logic [COUNT_W-1:0] cnt;
        logic [ACT_W-1:0]   act;
        logic [POS_W-1:0]   pos;
        target = n_sent + n_items;
        while (n_sent < target)
        begin
            case ($urandom_range(0, 7))
                0:       cnt = '0;
                1:       cnt = 15'h7FFF;
                2:       cnt = RESET_COUNT;
                3, 4:    cnt = COUNT_W'($urandom_range(1, 64));
                5:       cnt = COUNT_W'($urandom_range(1, 300));
                6:       cnt = COUNT_W'($urandom_range(0, 32767));
                default: cnt = COUNT_W'($urandom_range(60, 2000));
            endcase
            write_count(cnt);
            usable = (32'(cnt) > MAP_BITS) ? MAP_BITS : 32'(cnt);
            // hot region; for small counts a little past the end so range errors show up
            span     = (usable > 400) ? $urandom_range(64, 400) : usable + 4;
            fill_ptr = 0;
            quiet    = ($urandom_range(0, 3) == 0);
            len      = $urandom_range(30, 120);
            repeat (len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    act = ACT_FIND;
                else if (roll < 75)
                    act = ACT_SET;
                else if (roll < 95)
                    act = ACT_CLEAR;
                else
                    act = ACT_UNUSED;
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    pos = POS_W'($urandom_range(0, 16383));
                else if (roll < 50 && act == ACT_SET)
                begin
                    // sequential fill pushes the first free cluster deeper
                    pos = POS_W'(fill_ptr);
                    fill_ptr++;
                end
                else
                    pos = POS_W'($urandom_range(0, span));
                send_request(act, pos);
                if (!quiet)
                begin
                    gap = pick_gap();
                    if (gap != 0)
                        idle_for(gap);
                end
            end
        end
    endtask

    initial
    begin
        board    = new();
        n_sent   = 0;
        n_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(1100);
        idle_for(1);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("%0d requests under %0d count settings, %0d of them finds (%0d on a full map)",
                 n_sent, n_writes, board.n_find, board.n_full);
        $display("%0d sets, %0d clears, %0d unknown, %0d out of range, %0d result words checked",
                 board.n_set, board.n_clear, board.n_other, board.n_range, board.results_seen);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
